// File: rtl/dbpr_pkg.sv
// shared types and constants for the detection box to pixel rect block
package dbpr_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int MAX_FRAME_DIM_DEF = 8192;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 14;
    localparam int RATIO_W    = 16;
    localparam int COORD_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_SIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_BOTTOM = 3'd4;

    // coordinate modes
    localparam logic [1:0] MODE_CENTRE = 2'd0;
    localparam logic [1:0] MODE_IMAGE  = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]   frame_w;
        logic [DIM_W-1:0]   frame_h;
        logic [RATIO_W-1:0] pad_side;
        logic [RATIO_W-1:0] pad_top;
        logic [RATIO_W-1:0] pad_bottom;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [DIM_W-1:0] rect_x;
        logic [DIM_W-1:0] rect_y;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [1:0]       coord_mode;
        logic             rect_nonempty;
    } t_result;

endpackage

// File: rtl/detection_box_to_pixel_rect_core.sv
// top level: detection box to clipped pixel rectangle
// pipeline: 6 register stages, from transform products to the clip stage
// throughput: one item per cycle while the output is not stalled, a six stage pipeline that advances as a whole
// backpressure: the whole pipeline halts while the output item waits
// reset: synchronous active low; clears valid bits and restores the configuration registers to their defaults
module detection_box_to_pixel_rect_core
    import dbpr_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // box_left, box_top, box_right, box_bottom, shift_x, shift_y, gain_x, gain_y
    input  logic [255:0]          s_axis_tdata,
    // has_transform
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, rect_nonempty, zero fill
    output logic [63:0]           m_axis_tdata,
    // coord_mode
    output logic [1:0]            m_axis_tuser
);

    t_cfg    cfg;
    t_result res;
    logic    pipe_valid, en;

    // whole pipe moves when the output stage is free
    assign en            = !pipe_valid || m_axis_tready;
    assign s_axis_tready = en;

    dbpr_cfg_regs #(.MAX_FRAME_DIM(MAX_FRAME_DIM)) u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    dbpr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_en   (en),
        .i_valid(s_axis_tvalid),
        .i_l    (s_axis_tdata[31:0]),
        .i_t    (s_axis_tdata[63:32]),
        .i_r    (s_axis_tdata[95:64]),
        .i_b    (s_axis_tdata[127:96]),
        .i_tf   (s_axis_tuser),
        .i_sx   (s_axis_tdata[159:128]),
        .i_sy   (s_axis_tdata[191:160]),
        .i_gx   (s_axis_tdata[223:192]),
        .i_gy   (s_axis_tdata[255:224]),
        .i_cfg  (cfg),
        .o_valid(pipe_valid),
        .o_res  (res)
    );

    assign m_axis_tvalid = pipe_valid;
    assign m_axis_tdata  = {7'd0, res.rect_nonempty, res.rect_height, res.rect_width,
                            res.rect_y, res.rect_x};
    assign m_axis_tuser  = res.coord_mode;

endmodule

// File: rtl/dbpr_cfg_regs.sv
// configuration register file with frame size saturation
module dbpr_cfg_regs
    import dbpr_pkg::*;
#(
    parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [DIM_W-1:0]   r_frame_w, r_frame_h;
    logic [RATIO_W-1:0] r_pad_side, r_pad_top, r_pad_bottom;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w    <= DIM_W'(1920);
            r_frame_h    <= DIM_W'(1080);
            r_pad_side   <= '0;
            r_pad_top    <= '0;
            r_pad_bottom <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_W:    r_frame_w    <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_H:    r_frame_h    <= i_cfg_data[DIM_W-1:0];
                REG_PAD_SIDE:   r_pad_side   <= i_cfg_data[RATIO_W-1:0];
                REG_PAD_TOP:    r_pad_top    <= i_cfg_data[RATIO_W-1:0];
                REG_PAD_BOTTOM: r_pad_bottom <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate frame size to the largest supported dimension
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(MAX_FRAME_DIM)) return DIM_W'(MAX_FRAME_DIM);
        return v;
    endfunction

    assign o_cfg.frame_w    = sat_dim(r_frame_w);
    assign o_cfg.frame_h    = sat_dim(r_frame_h);
    assign o_cfg.pad_side   = r_pad_side;
    assign o_cfg.pad_top    = r_pad_top;
    assign o_cfg.pad_bottom = r_pad_bottom;

endmodule

// File: rtl/dbpr_datapath.sv
// pipelined datapath: transform, classify, map, pad and clip
module dbpr_datapath
    import dbpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_l,
    input  logic signed [31:0] i_t,
    input  logic signed [31:0] i_r,
    input  logic signed [31:0] i_b,
    input  logic               i_tf,
    input  logic signed [31:0] i_sx,
    input  logic signed [31:0] i_sy,
    input  logic signed [31:0] i_gx,
    input  logic signed [31:0] i_gy,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output t_result            o_res
);

    localparam int     PW     = 66;
    localparam longint ONE    = longint'(1) << FRAC_BITS;
    localparam longint LIM    = ONE + ONE / 4;
    localparam longint EPS    = (ONE + 500) / 1000;
    localparam int     SW     = 48;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6} <= '0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end
    assign o_valid = r_v6;

    // ---------------- stage 1: transform products ----------------
    logic signed [63:0] r_pl, r_pt, r_pr, r_pb;
    logic signed [31:0] r_sx1, r_sy1, r_l1, r_t1, r_r1, r_b1;
    logic               r_tf1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl  <= 64'(i_l) * 64'(i_gx);
            r_pr  <= 64'(i_r) * 64'(i_gx);
            r_pt  <= 64'(i_t) * 64'(i_gy);
            r_pb  <= 64'(i_b) * 64'(i_gy);
            r_sx1 <= i_sx;
            r_sy1 <= i_sy;
            r_l1  <= i_l;
            r_t1  <= i_t;
            r_r1  <= i_r;
            r_b1  <= i_b;
            r_tf1 <= i_tf;
        end
    end

    // product plus shift, floor, saturate
    function automatic logic signed [31:0] tf_fin(input logic signed [63:0] p,
                                                  input logic signed [31:0] s);
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] q;
        a = PW'(p) + (PW'(s) <<< FRAC_BITS);
        q = a >>> FRAC_BITS;
        if (q > PW'(64'sd2147483647)) return 32'sh7fffffff;
        if (q < -PW'(64'sd2147483648)) return 32'sh80000000;
        return q[31:0];
    endfunction

    // stage 2: finish transform, or pass the box through when there is none
    logic signed [31:0] r_l2, r_t2, r_r2, r_b2;
    logic               r_tf2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tf2 <= r_tf1;
            if (r_tf1) begin
                r_l2 <= tf_fin(r_pl, r_sx1);
                r_r2 <= tf_fin(r_pr, r_sx1);
                r_t2 <= tf_fin(r_pt, r_sy1);
                r_b2 <= tf_fin(r_pb, r_sy1);
            end else begin
                r_l2 <= r_l1;
                r_r2 <= r_r1;
                r_t2 <= r_t1;
                r_b2 <= r_b1;
            end
        end
    end

    // ---------------- stage 3: classify, pick edges, premultiply ----------------
    logic signed [31:0] xmn, xmx, ymn, ymx, amn, amx;
    logic [1:0]         mode3;
    logic signed [33:0] ex_l, ex_h, ey_l, ey_h;
    always_comb begin
        xmn = (r_l2 < r_r2) ? r_l2 : r_r2;
        xmx = (r_l2 > r_r2) ? r_l2 : r_r2;
        ymn = (r_t2 < r_b2) ? r_t2 : r_b2;
        ymx = (r_t2 > r_b2) ? r_t2 : r_b2;
        amn = (xmn < ymn) ? xmn : ymn;
        amx = (xmx > ymx) ? xmx : ymx;
        mode3 = MODE_PIXEL;
        if (r_tf2) begin
            mode3 = MODE_CENTRE;
        end else if (64'(amn) >= -LIM && 64'(amx) <= LIM) begin
            if (64'(amn) >= -EPS && 64'(amx) <= ONE + EPS && r_t2 < r_b2)
                mode3 = MODE_IMAGE;
            else
                mode3 = MODE_CENTRE;
        end
        if (mode3 == MODE_CENTRE) begin
            ex_l = 34'(xmn) + 34'(ONE);
            ex_h = 34'(xmx) + 34'(ONE);
            ey_l = 34'(ONE) - 34'(ymx);
            ey_h = 34'(ONE) - 34'(ymn);
        end else begin
            ex_l = 34'(xmn);
            ex_h = 34'(xmx);
            ey_l = 34'(ymn);
            ey_h = 34'(ymx);
        end
    end

    logic signed [SW-1:0] r_xl, r_xh, r_yl, r_yh;
    logic [1:0]           r_m3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m3 <= mode3;
            if (mode3 == MODE_PIXEL) begin
                r_xl <= SW'(ex_l); r_xh <= SW'(ex_h);
                r_yl <= SW'(ey_l); r_yh <= SW'(ey_h);
            end else begin
                r_xl <= SW'(ex_l) * SW'($signed({1'b0, i_cfg.frame_w}));
                r_xh <= SW'(ex_h) * SW'($signed({1'b0, i_cfg.frame_w}));
                r_yl <= SW'(ey_l) * SW'($signed({1'b0, i_cfg.frame_h}));
                r_yh <= SW'(ey_h) * SW'($signed({1'b0, i_cfg.frame_h}));
            end
        end
    end

    // ---------------- stage 4: floor/ceil to pixels, size ----------------
    localparam int IW = SW - FRAC_BITS + 1;
    logic signed [IW-1:0] x1, y1, xc, yc, bw, bh;
    always_comb begin
        if (r_m3 == MODE_CENTRE) begin
            x1 = IW'(r_xl >>> (FRAC_BITS + 1));
            y1 = IW'(r_yl >>> (FRAC_BITS + 1));
            xc = -IW'((-r_xh) >>> (FRAC_BITS + 1));
            yc = -IW'((-r_yh) >>> (FRAC_BITS + 1));
        end else begin
            x1 = IW'(r_xl >>> FRAC_BITS);
            y1 = IW'(r_yl >>> FRAC_BITS);
            xc = -IW'((-r_xh) >>> FRAC_BITS);
            yc = -IW'((-r_yh) >>> FRAC_BITS);
        end
        bw = xc - x1;
        bh = yc - y1;
        if (bw < IW'(1)) bw = IW'(1);
        if (bh < IW'(1)) bh = IW'(1);
    end

    logic signed [IW-1:0] r_x1, r_y1;
    logic [IW-2:0]        r_bw, r_bh;
    logic [1:0]           r_m4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= x1;
            r_y1 <= y1;
            r_bw <= bw[IW-2:0];
            r_bh <= bh[IW-2:0];
            r_m4 <= r_m3;
        end
    end

    // ---------------- stage 5: padding products and rounding ----------------
    localparam int BW = IW - 1;
    function automatic logic [BW-1:0] pad_of(input logic [BW-1:0] sz,
                                             input logic [RATIO_W-1:0] ra);
        logic [BW+RATIO_W-1:0] p;
        logic [BW-1:0]         q;
        logic [15:0]           rem;
        p   = (BW + RATIO_W)'(sz) * (BW + RATIO_W)'(ra);
        q   = p[BW+RATIO_W-1:16];
        rem = p[15:0];
        if (rem > 16'h8000 || (rem == 16'h8000 && q[0])) q = q + BW'(1);
        if (q == '0) q = BW'(1);
        return q;
    endfunction

    logic signed [IW+1:0] r_ax1, r_ay1, r_ax2, r_ay2;
    logic [1:0]           r_m5;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [BW-1:0] px, pt, pb;
            px = pad_of(r_bw, i_cfg.pad_side);
            pt = pad_of(r_bh, i_cfg.pad_top);
            pb = pad_of(r_bh, i_cfg.pad_bottom);
            r_ax1 <= (IW+2)'(r_x1) - (IW+2)'(px);
            r_ay1 <= (IW+2)'(r_y1) - (IW+2)'(pt);
            r_ax2 <= (IW+2)'(r_x1) + (IW+2)'(r_bw) + (IW+2)'(px);
            r_ay2 <= (IW+2)'(r_y1) + (IW+2)'(r_bh) + (IW+2)'(pb);
            r_m5  <= r_m4;
        end
    end

    // ---------------- stage 6: clip to frame ----------------
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic signed [IW+1:0] c1x, c1y, c2x, c2y, fw, fh;
            fw  = (IW+2)'($signed({1'b0, i_cfg.frame_w}));
            fh  = (IW+2)'($signed({1'b0, i_cfg.frame_h}));
            c1x = (r_ax1 > 0) ? r_ax1 : '0;
            c1y = (r_ay1 > 0) ? r_ay1 : '0;
            c2x = (r_ax2 < fw) ? r_ax2 : fw;
            c2y = (r_ay2 < fh) ? r_ay2 : fh;
            o_res.coord_mode <= r_m5;
            if (fw == 0 || fh == 0 || c2x <= c1x || c2y <= c1y) begin
                o_res.rect_x        <= '0;
                o_res.rect_y        <= '0;
                o_res.rect_width    <= '0;
                o_res.rect_height   <= '0;
                o_res.rect_nonempty <= 1'b0;
            end else begin
                o_res.rect_x        <= c1x[DIM_W-1:0];
                o_res.rect_y        <= c1y[DIM_W-1:0];
                o_res.rect_width    <= DIM_W'(c2x - c1x);
                o_res.rect_height   <= DIM_W'(c2y - c1y);
                o_res.rect_nonempty <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/dbpr_checker.sv
// port-level checker for the detection box to pixel rect core
module dbpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        s_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty flag matches zero size
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[56] |-> m_axis_tdata[55:0] == 56'd0)
        else $error("empty result has nonzero fields");

    // nonempty has positive size
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[56] |->
            m_axis_tdata[41:28] != 14'd0 && m_axis_tdata[55:42] != 14'd0)
        else $error("nonempty result with zero size");

    // mode code is valid
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad mode");

    // ready follows the output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output free");

endmodule

bind detection_box_to_pixel_rect_core dbpr_checker u_dbpr_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser
);

// File: dv/tb_detection_box_to_pixel_rect_core.sv
// testbench for the detection box to pixel rectangle block: random and directed boxes
module tb_detection_box_to_pixel_rect_core;
    import dbpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_FX   = 64'sd65536;
    localparam longint LIM_FX   = ONE_FX + ONE_FX / 4;
    localparam longint EPS_FX   = 64'sd66;
    localparam int     MAX_DIM  = 8192;
    localparam int     CYC_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] gain_y;
        logic [31:0] gain_x;
        logic [31:0] shift_y;
        logic [31:0] shift_x;
        logic [31:0] bottom;
        logic [31:0] right;
        logic [31:0] top;
        logic [31:0] left;
        logic        has_tf;
    } t_box;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [255:0]          s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    detection_box_to_pixel_rect_core dut (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [DIM_W-1:0]   frame_w_q = 14'd1920;
    logic [DIM_W-1:0]   frame_h_q = 14'd1080;
    logic [RATIO_W-1:0] pad_side_q = '0, pad_top_q = '0, pad_bottom_q = '0;

    t_box    box_queue[$];
    t_result rect_queue[$];
    int      n_sent = 0, n_checked = 0, n_errors = 0, cycle_cnt = 0;
    bit      hold_off = 1'b0;

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint ceil_shift(longint v, int k);
        return -((-v) >>> k);
    endfunction

    function automatic longint transform(longint v, longint g, longint s);
        longint r;
        r = floor_shift(v * g + s * ONE_FX, 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // round half to even, never below one
    function automatic longint pad_amount(longint size, logic [15:0] ratio);
        longint p, q, r;
        p = size * longint'(ratio);
        q = p >>> 16;
        r = p & 64'hFFFF;
        if (r > 64'h8000 || (r == 64'h8000 && q[0])) q++;
        return (q < 1) ? 1 : q;
    endfunction

    function automatic t_result predict_rect(t_box b);
        t_result res;
        longint l, t, r, bt, w, h, mn, mx, xl, xh, yl, yh, x1, y1, x2, y2;
        longint bw, bh, px, pt, pb, cx1, cy1, cx2, cy2;
        logic [1:0] mode;
        int k;
        res = '0;
        l = longint'($signed(b.left));
        t = longint'($signed(b.top));
        r = longint'($signed(b.right));
        bt = longint'($signed(b.bottom));
        w = (frame_w_q > MAX_DIM) ? MAX_DIM : frame_w_q;
        h = (frame_h_q > MAX_DIM) ? MAX_DIM : frame_h_q;
        mode = MODE_PIXEL;
        if (b.has_tf) begin
            l = transform(l, $signed(b.gain_x), $signed(b.shift_x));
            r = transform(r, $signed(b.gain_x), $signed(b.shift_x));
            t = transform(t, $signed(b.gain_y), $signed(b.shift_y));
            bt = transform(bt, $signed(b.gain_y), $signed(b.shift_y));
            mode = MODE_CENTRE;
        end else begin
            mn = l; mx = l;
            if (t < mn) mn = t;
            if (r < mn) mn = r;
            if (bt < mn) mn = bt;
            if (t > mx) mx = t;
            if (r > mx) mx = r;
            if (bt > mx) mx = bt;
            if (mn >= -LIM_FX && mx <= LIM_FX) begin
                if (mn >= -EPS_FX && mx <= ONE_FX + EPS_FX && t < bt) mode = MODE_IMAGE;
                else mode = MODE_CENTRE;
            end
        end
        res.coord_mode = mode;
        if (w == 0 || h == 0) return res;
        xl = (l < r) ? l : r;
        xh = (l < r) ? r : l;
        yl = (t < bt) ? t : bt;
        yh = (t < bt) ? bt : t;
        k = 16;
        if (mode == MODE_CENTRE) begin
            mn = yl;
            yl = (ONE_FX - yh) * h;
            yh = (ONE_FX - mn) * h;
            xl = (xl + ONE_FX) * w;
            xh = (xh + ONE_FX) * w;
            k = 17;
        end else if (mode == MODE_IMAGE) begin
            xl = xl * w; xh = xh * w; yl = yl * h; yh = yh * h;
        end
        x1 = floor_shift(xl, k);
        y1 = floor_shift(yl, k);
        bw = ceil_shift(xh, k) - x1;
        bh = ceil_shift(yh, k) - y1;
        if (bw < 1) bw = 1;
        if (bh < 1) bh = 1;
        px = pad_amount(bw, pad_side_q);
        pt = pad_amount(bh, pad_top_q);
        pb = pad_amount(bh, pad_bottom_q);
        x2 = x1 + bw + px;
        y2 = y1 + bh + pb;
        x1 -= px;
        y1 -= pt;
        cx1 = (x1 > 0) ? x1 : 0;
        cy1 = (y1 > 0) ? y1 : 0;
        cx2 = (x2 < w) ? x2 : w;
        cy2 = (y2 < h) ? y2 : h;
        if (cx2 - cx1 <= 0 || cy2 - cy1 <= 0) return res;
        res.rect_x = cx1[13:0];
        res.rect_y = cy1[13:0];
        res.rect_width = 14'(cx2 - cx1);
        res.rect_height = 14'(cy2 - cy1);
        res.rect_nonempty = 1'b1;
        return res;
    endfunction

    // append one box to the pending stimulus
    task automatic add_box(t_box b);
        box_queue = {box_queue, b};
    endtask

    // driver: bursts and gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (burst_left > 0 && box_queue.size() > 0) begin
                    t_box b;
                    b = box_queue.pop_front();
                    s_axis_tdata <= {b.gain_y, b.gain_x, b.shift_y, b.shift_x,
                                     b.bottom, b.right, b.top, b.left};
                    s_axis_tuser <= b.has_tf;
                    s_axis_tvalid <= 1'b1;
                    rect_queue = {rect_queue, predict_rect(b)};
                    n_sent++;
                    burst_left--;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0) gap_left--;
                    else if (box_queue.size() == 0) burst_left = 0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    int stall_phase = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        stall_phase = (stall_phase + 1) % 23;
        if (hold_off && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            m_axis_tready <= 1'b0;
        end else if (stall_phase < 8) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result want, got;
            got.rect_x = m_axis_tdata[13:0];
            got.rect_y = m_axis_tdata[27:14];
            got.rect_width = m_axis_tdata[41:28];
            got.rect_height = m_axis_tdata[55:42];
            got.rect_nonempty = m_axis_tdata[56];
            got.coord_mode = m_axis_tuser;
            if (rect_queue.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %p", $realtime, got);
                n_errors++;
            end else begin
                want = rect_queue.pop_front();
                if (got.rect_x !== want.rect_x)
                    $display("%0t: rect_x expected %0d actual %0d", $realtime,
                             want.rect_x, got.rect_x);
                if (got.rect_y !== want.rect_y)
                    $display("%0t: rect_y expected %0d actual %0d", $realtime,
                             want.rect_y, got.rect_y);
                if (got.rect_width !== want.rect_width)
                    $display("%0t: rect_width expected %0d actual %0d", $realtime,
                             want.rect_width, got.rect_width);
                if (got.rect_height !== want.rect_height)
                    $display("%0t: rect_height expected %0d actual %0d", $realtime,
                             want.rect_height, got.rect_height);
                if (got.coord_mode !== want.coord_mode)
                    $display("%0t: coord_mode expected %0d actual %0d", $realtime,
                             want.coord_mode, got.coord_mode);
                if (got.rect_nonempty !== want.rect_nonempty)
                    $display("%0t: rect_nonempty expected %0d actual %0d", $realtime,
                             want.rect_nonempty, got.rect_nonempty);
                if (got !== want) n_errors++;
                n_checked++;
            end
        end
        if (cycle_cnt > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_detection_box_to_pixel_rect_core: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65600);
            1: return -$urandom_range(0, 81920) + $urandom_range(0, 163840);
            2: return $urandom_range(0, 2000) << 16 | $urandom_range(0, 65535);
            3: return $urandom;
            default: return -32'sd70000 + $urandom_range(0, 150000);
        endcase
    endfunction

    function automatic t_box rand_box();
        t_box b;
        b.has_tf = $urandom_range(0, 2) == 0;
        b.left = rand_coord();
        b.right = ($urandom_range(0, 3) == 0) ? $urandom : b.left + $urandom_range(0, 30000);
        b.top = rand_coord();
        b.bottom = ($urandom_range(0, 3) == 0) ? $urandom : b.top + $urandom_range(0, 30000);
        b.shift_x = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4) - 2;
        b.shift_y = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4) - 2;
        b.gain_x = ($urandom_range(0, 7) == 0) ? $urandom : 32'sd65536 - $urandom_range(0, 131072);
        b.gain_y = ($urandom_range(0, 7) == 0) ? $urandom : 32'sd65536 - $urandom_range(0, 131072);
        return b;
    endfunction

    function automatic t_box make_box(logic [31:0] l, logic [31:0] t, logic [31:0] r,
                                      logic [31:0] bt);
        t_box b;
        b = '0;
        b.left = l; b.top = t; b.right = r; b.bottom = bt;
        return b;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_W:    frame_w_q = val[13:0];
            REG_FRAME_H:    frame_h_q = val[13:0];
            REG_PAD_SIDE:   pad_side_q = val;
            REG_PAD_TOP:    pad_top_q = val;
            REG_PAD_BOTTOM: pad_bottom_q = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (box_queue.size() > 0 || s_axis_tvalid || rect_queue.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        repeat (n) add_box(rand_box());
        drain();
    endtask

    initial begin
        t_box b;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each mode, extremes, degenerate and transformed boxes
        add_box(make_box(32'h0000_4000, 32'h0000_4000, 32'h0000_C000, 32'h0000_C000));
        add_box(make_box(32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000));
        add_box(make_box(32'h0000_8000, 32'h0000_C000, 32'h0000_C000, 32'h0000_4000));
        add_box(make_box(-32'sd66, -32'sd66, 32'h0001_0042, 32'h0001_0042));
        add_box(make_box(-32'sd67, 32'd0, 32'h0001_0000, 32'h0001_0000));
        add_box(make_box(32'hFFFE_C000, 32'hFFFE_C000, 32'h0001_4000, 32'h0001_4000));
        add_box(make_box(32'hFFFE_BFFF, 32'd0, 32'd0, 32'd1));
        add_box(make_box(32'h0064_0000, 32'h0032_0000, 32'h00C8_8000, 32'h0096_0001));
        add_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_box(make_box(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000));
        add_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        b = make_box(32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000);
        b.has_tf = 1'b1; b.gain_x = 32'h0001_0000; b.gain_y = 32'h0001_0000;
        add_box(b);
        b.shift_x = 32'hFFFF_FFFF; b.shift_y = 32'h0000_0001; b.gain_y = 32'hFFFF_0000;
        add_box(b);
        b.gain_x = 32'h7FFF_FFFF; b.gain_y = 32'h8000_0000;
        b.shift_x = 32'h7FFF_FFFF; b.shift_y = 32'h8000_0000;
        add_box(b);
        b = make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        b.has_tf = 1'b1; b.gain_x = '1; b.gain_y = '1; b.shift_x = '1; b.shift_y = '1;
        add_box(b);
        drain();

        // long receiver hold-off so the pipeline backs up
        hold_off = 1'b1;
        repeat (40) add_box(rand_box());
        wait (hold_cnt >= HOLD_CYCLES);
        hold_off = 1'b0;
        drain();

        run_random(200);

        // padding and large frame
        write_reg(REG_PAD_SIDE, 16'h2000);
        write_reg(REG_PAD_TOP, 16'h8000);
        write_reg(REG_PAD_BOTTOM, 16'h0800);
        write_reg(REG_FRAME_W, 16'd8192);
        write_reg(REG_FRAME_H, 16'h3FFF);
        run_random(200);

        // maximum ratios, tiny frame
        write_reg(REG_PAD_SIDE, 16'hFFFF);
        write_reg(REG_PAD_TOP, 16'hFFFF);
        write_reg(REG_PAD_BOTTOM, 16'hFFFF);
        write_reg(REG_FRAME_W, 16'd1);
        write_reg(REG_FRAME_H, 16'd3);
        run_random(150);

        // zero frame sizes and an unknown index
        write_reg(REG_FRAME_W, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        run_random(60);
        write_reg(REG_FRAME_W, 16'd640);
        write_reg(REG_FRAME_H, 16'd0);
        run_random(60);

        // ordinary setting with mixed ratios
        write_reg(REG_FRAME_H, 16'd480);
        write_reg(REG_PAD_SIDE, 16'h1000);
        write_reg(REG_PAD_TOP, 16'h0000);
        write_reg(REG_PAD_BOTTOM, 16'h4000);
        run_random(340);

        $display("covered %0d boxes over six register settings, %0d results checked",
                 n_sent, n_checked);
        $display("modes, padding extremes, zero and oversized frames and backpressure exercised");
        if (n_errors == 0 && rect_queue.size() == 0)
            $display("tb_detection_box_to_pixel_rect_core: done, clean");
        else
            $display("tb_detection_box_to_pixel_rect_core: done, errors");
        $finish;
    end

endmodule

// File: detection_box_to_pixel_rect_core.f
rtl/dbpr_pkg.sv
rtl/dbpr_cfg_regs.sv
rtl/dbpr_datapath.sv
rtl/detection_box_to_pixel_rect_core.sv
rtl/dbpr_checker.sv
dv/tb_detection_box_to_pixel_rect_core.sv
